// ----- rtl/core/ffba_pkg.sv -----
// Shared types and codes for the first-fit block allocator.
// Used by ffba_table and first_fit_block_allocator; depends on nothing else.
`timescale 1ns / 1ps

package ffba_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned STAT_W  = 3;
  // Running gap position and the position plus a request length.
  localparam int unsigned POS_W   = 10;
  localparam int unsigned SUM_W   = 11;

  // One table entry, as stored in the entry memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [SIZE_W-1:0]  length;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOBLOCK  = 3'd2,
    ST_NOTOWNER = 3'd3,
    ST_NOSPACE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME,
    S_A_SCAN,
    S_A_FIT,
    S_A_PRIME,
    S_A_SHIFT,
    S_A_INS,
    S_F_SCAN,
    S_F_SHIFT,
    S_FIN
  } state_t;

endpackage

// ----- rtl/core/ffba_table.sv -----
// Entry memory of the first-fit block allocator: one write port and one
// read port with registered read data. Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  ffba_pkg::entry_t               wr_data,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output ffba_pkg::entry_t               rd_data
);

  ffba_pkg::entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data appears the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/first_fit_block_allocator.sv -----
// First-fit block allocator top level: request sequencer and result register.
// Depends on ffba_pkg and ffba_table.
`timescale 1ns / 1ps

// The allocator keeps up to MAX_BLOCKS allocated blocks in an entry memory
// sorted by start address. An allocate walks the entries from address 0, one
// entry per cycle through the memory read port, to find the first gap that
// fits, then moves the later entries up by one, one entry per cycle, and
// writes the new block. A free walks the entries to find the start address
// and moves the later entries down by one per cycle. Zero-size allocates and
// allocates to a full table skip the walk; the walks are paced by the single
// read and write port of the entry memory. A finished request waits while the
// previous result still waits in the output register; s_tready is high only
// between requests. Each request gives exactly one result transfer, and a
// new request may be taken while the previous result still waits.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned MEM_WORDS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: alloc_size [8:0], block_address [16:9], owner_id [24:17], zeros above
  input  logic [31:0] s_tdata,
  // s_tuser: cmd [0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: result_address [7:0], status [10:8], zeros above
  output logic [15:0] m_tdata
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_SPACE = (MEM_WORDS < 256) ? MEM_WORDS : 256;

  localparam int unsigned AW = ffba_pkg::ADDR_W;
  localparam int unsigned SW = ffba_pkg::SIZE_W;
  localparam int unsigned OW = ffba_pkg::OWNER_W;
  localparam int unsigned PW = ffba_pkg::POS_W;
  localparam int unsigned UW = ffba_pkg::SUM_W;

  ffba_pkg::state_t  state, state_next;
  ffba_pkg::cmd_t    cmd, cmd_next;
  logic [SW-1:0]     req_size, req_size_next;
  logic [AW-1:0]     req_addr, req_addr_next;
  logic [OW-1:0]     req_owner, req_owner_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [PW-1:0]     pos, pos_next;
  logic [AW-1:0]     res_addr, res_addr_next;
  ffba_pkg::status_t res_status, res_status_next;
  logic [AW-1:0]     out_addr, out_addr_next;
  ffba_pkg::status_t out_status, out_status_next;
  logic              out_valid, out_valid_next;

  logic              tbl_wr_en;
  logic [IW-1:0]     tbl_wr_addr;
  ffba_pkg::entry_t  tbl_wr_data;
  logic [IW-1:0]     tbl_rd_addr;
  ffba_pkg::entry_t  tbl_rd_data;

  // Shared adder and compare for the gap search.
  logic [UW-1:0]     need;
  logic [PW-1:0]     entry_end;

  assign need      = UW'(pos) + UW'(req_size);
  assign entry_end = PW'(tbl_rd_data.start) + PW'(tbl_rd_data.length);

  ffba_table #(
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffba_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    req_size   <= req_size_next;
    req_addr   <= req_addr_next;
    req_owner  <= req_owner_next;
    idx        <= idx_next;
    ptr        <= ptr_next;
    pos        <= pos_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    out_addr   <= out_addr_next;
    out_status <= out_status_next;
  end

  assign s_tready = (state == ffba_pkg::S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_status, out_addr};

  // Sequencer: next state, register updates and memory port control.
  always_comb begin
    logic [CW:0] idx_p1;
    logic [CW:0] idx_p2;
    logic [CW:0] ptr_m1;
    logic [CW:0] ptr_m2;
    logic [CW:0] cnt_m1;

    idx_p1 = (CW+1)'(idx) + (CW+1)'(1);
    idx_p2 = (CW+1)'(idx) + (CW+1)'(2);
    ptr_m1 = (CW+1)'(ptr) - (CW+1)'(1);
    ptr_m2 = (CW+1)'(ptr) - (CW+1)'(2);
    cnt_m1 = (CW+1)'(count) - (CW+1)'(1);

    state_next      = state;
    cmd_next        = cmd;
    req_size_next   = req_size;
    req_addr_next   = req_addr;
    req_owner_next  = req_owner;
    count_next      = count;
    idx_next        = idx;
    ptr_next        = ptr;
    pos_next        = pos;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    out_addr_next   = out_addr;
    out_status_next = out_status;
    out_valid_next  = out_valid;

    tbl_wr_en   = 1'b0;
    tbl_wr_addr = idx[IW-1:0];
    tbl_wr_data = tbl_rd_data;
    tbl_rd_addr = idx_p1[IW-1:0];

    // The downstream side takes the pending result.
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ffba_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd_next        = ffba_pkg::cmd_t'(s_tuser[0]);
          req_size_next   = s_tdata[SW-1:0];
          req_addr_next   = s_tdata[SW+AW-1:SW];
          req_owner_next  = s_tdata[SW+AW+OW-1:SW+AW];
          res_addr_next   = '0;
          res_status_next = ffba_pkg::ST_OK;
          idx_next        = '0;
          pos_next        = '0;
          if (ffba_pkg::cmd_t'(s_tuser[0]) == ffba_pkg::CMD_FREE) begin
            state_next = ffba_pkg::S_PRIME;
          end else if (s_tdata[SW-1:0] == '0) begin
            res_status_next = ffba_pkg::ST_ZERO;
            state_next      = ffba_pkg::S_FIN;
          end else if (count == CW'(MAX_BLOCKS)) begin
            res_status_next = ffba_pkg::ST_NOSPACE;
            state_next      = ffba_pkg::S_FIN;
          end else begin
            state_next = ffba_pkg::S_PRIME;
          end
        end
      end

      // Fetch the first entry ahead of the walk.
      ffba_pkg::S_PRIME: begin
        tbl_rd_addr = '0;
        state_next  = (cmd == ffba_pkg::CMD_FREE) ? ffba_pkg::S_F_SCAN : ffba_pkg::S_A_SCAN;
      end

      // Gap search: stop at the first entry that starts at or past the need, or at the end of the table.
      ffba_pkg::S_A_SCAN: begin
        if (idx == count) begin
          state_next = ffba_pkg::S_A_FIT;
        end else if (UW'(tbl_rd_data.start) >= need) begin
          state_next = ffba_pkg::S_A_FIT;
        end else begin
          pos_next = entry_end;
          idx_next = idx_p1[CW-1:0];
        end
      end

      // The gap must end inside the usable address space.
      ffba_pkg::S_A_FIT: begin
        if (need > UW'(ADDR_SPACE)) begin
          res_status_next = ffba_pkg::ST_NOSPACE;
          state_next      = ffba_pkg::S_FIN;
        end else if (idx == count) begin
          state_next = ffba_pkg::S_A_INS;
        end else begin
          ptr_next   = count;
          state_next = ffba_pkg::S_A_PRIME;
        end
      end

      // Fetch the last entry before moving entries up.
      ffba_pkg::S_A_PRIME: begin
        tbl_rd_addr = cnt_m1[IW-1:0];
        state_next  = ffba_pkg::S_A_SHIFT;
      end

      // Move entry ptr-1 to ptr, walking down to the insertion point.
      ffba_pkg::S_A_SHIFT: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = ptr[IW-1:0];
        tbl_wr_data = tbl_rd_data;
        tbl_rd_addr = ptr_m2[IW-1:0];
        ptr_next    = ptr_m1[CW-1:0];
        if (ptr_m1[CW-1:0] == idx) begin
          state_next = ffba_pkg::S_A_INS;
        end
      end

      // Write the new block at the insertion point.
      ffba_pkg::S_A_INS: begin
        tbl_wr_en          = 1'b1;
        tbl_wr_addr        = idx[IW-1:0];
        tbl_wr_data.start  = pos[AW-1:0];
        tbl_wr_data.length = req_size;
        tbl_wr_data.owner  = req_owner;
        count_next         = CW'((CW+1)'(count) + (CW+1)'(1));
        res_addr_next      = pos[AW-1:0];
        res_status_next    = ffba_pkg::ST_OK;
        state_next         = ffba_pkg::S_FIN;
      end

      // Free: look for the entry with the given start.
      ffba_pkg::S_F_SCAN: begin
        if (idx == count) begin
          res_status_next = ffba_pkg::ST_NOBLOCK;
          state_next      = ffba_pkg::S_FIN;
        end else if (tbl_rd_data.start == req_addr) begin
          if (tbl_rd_data.owner != req_owner) begin
            res_status_next = ffba_pkg::ST_NOTOWNER;
            state_next      = ffba_pkg::S_FIN;
          end else begin
            state_next = ffba_pkg::S_F_SHIFT;
          end
        end else begin
          idx_next = idx_p1[CW-1:0];
        end
      end

      // Move entry idx+1 down to idx until the end of the table.
      ffba_pkg::S_F_SHIFT: begin
        tbl_rd_addr = idx_p2[IW-1:0];
        if (idx_p1 < (CW+1)'(count)) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = idx[IW-1:0];
          tbl_wr_data = tbl_rd_data;
          idx_next    = idx_p1[CW-1:0];
        end else begin
          count_next      = cnt_m1[CW-1:0];
          res_status_next = ffba_pkg::ST_OK;
          state_next      = ffba_pkg::S_FIN;
        end
      end

      // Hand the result to the output register once it is free.
      ffba_pkg::S_FIN: begin
        if (!out_valid || m_tready) begin
          out_addr_next   = res_addr;
          out_status_next = res_status;
          out_valid_next  = 1'b1;
          state_next      = ffba_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ffba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- dv/first_fit_block_allocator_tb.sv -----
// Self-checking testbench for first_fit_block_allocator: directed corner cases, then random
// allocate and free traffic checked against a block table kept in the testbench.
// Depends on ffba_pkg and the allocator RTL.
`timescale 1ns / 1ps

localparam int unsigned TB_MAX_BLOCKS = 16;
localparam int unsigned TB_ADDR_SPACE = 256;

// One expected result transfer.
typedef struct packed {
  logic [ffba_pkg::ADDR_W-1:0] addr;
  ffba_pkg::status_t           status;
} alloc_reply_t;

// Mirror of the allocator's sorted block table plus the queue of replies it owes.
class alloc_table_tracker;
  ffba_pkg::entry_t blocks[TB_MAX_BLOCKS];
  int unsigned      used;
  alloc_reply_t     owed_replies[$];
  int unsigned      errors;
  int unsigned      n_alloc;
  int unsigned      n_free;
  int unsigned      peak_used;
  int unsigned      outcome_cnt[5];

  function new();
    used      = 0;
    errors    = 0;
    n_alloc   = 0;
    n_free    = 0;
    peak_used = 0;
    foreach (outcome_cnt[i]) outcome_cnt[i] = 0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  function int unsigned outstanding();
    return owed_replies.size();
  endfunction

  // First fit: walk the sorted blocks from address 0 and take the first gap that holds size.
  function ffba_pkg::status_t alloc_block(input logic [ffba_pkg::SIZE_W-1:0] size,
                                          input logic [ffba_pkg::OWNER_W-1:0] owner,
                                          output logic [ffba_pkg::ADDR_W-1:0] start_out);
    logic [ffba_pkg::POS_W-1:0] pos;
    logic [ffba_pkg::SUM_W-1:0] fit_end;
    int unsigned                slot;
    int unsigned                i;
    start_out = '0;
    if (size == 0) return ffba_pkg::ST_ZERO;
    if (used >= TB_MAX_BLOCKS) return ffba_pkg::ST_NOSPACE;
    pos  = '0;
    slot = used;
    for (i = 0; i < used; i++) begin
      fit_end = pos + size;
      if (blocks[i].start >= fit_end) begin
        slot = i;
        break;
      end
      pos = blocks[i].start + blocks[i].length;
    end
    fit_end = pos + size;
    if (fit_end > TB_ADDR_SPACE) return ffba_pkg::ST_NOSPACE;
    // Open a hole at the insertion point so the table stays sorted.
    for (i = used; i > slot; i--) blocks[i] = blocks[i-1];
    blocks[slot].start  = pos[ffba_pkg::ADDR_W-1:0];
    blocks[slot].length = size;
    blocks[slot].owner  = owner;
    used++;
    if (used > peak_used) peak_used = used;
    start_out = pos[ffba_pkg::ADDR_W-1:0];
    return ffba_pkg::ST_OK;
  endfunction

  // A free only succeeds when the start matches a block and the owner matches too.
  function ffba_pkg::status_t free_block(input logic [ffba_pkg::ADDR_W-1:0] addr,
                                         input logic [ffba_pkg::OWNER_W-1:0] owner);
    int unsigned slot;
    int unsigned i;
    slot = used;
    for (i = 0; i < used; i++) begin
      if (blocks[i].start == addr) begin
        slot = i;
        break;
      end
    end
    if (slot == used) return ffba_pkg::ST_NOBLOCK;
    if (blocks[slot].owner != owner) return ffba_pkg::ST_NOTOWNER;
    for (i = slot; i + 1 < used; i++) blocks[i] = blocks[i+1];
    used--;
    return ffba_pkg::ST_OK;
  endfunction

  function void note_request(input ffba_pkg::cmd_t cmd,
                             input logic [ffba_pkg::SIZE_W-1:0] size,
                             input logic [ffba_pkg::ADDR_W-1:0] addr,
                             input logic [ffba_pkg::OWNER_W-1:0] owner);
    alloc_reply_t reply;
    reply.addr = '0;
    if (cmd == ffba_pkg::CMD_ALLOC) begin
      n_alloc++;
      reply.status = alloc_block(size, owner, reply.addr);
    end else begin
      n_free++;
      reply.status = free_block(addr, owner);
    end
    outcome_cnt[reply.status]++;
    owed_replies.push_back(reply);
  endfunction

  function void check_result(input logic [15:0] word);
    alloc_reply_t want;
    if (owed_replies.size() == 0) begin
      flag($sformatf("result addr=%0d status=%0d with no request outstanding",
                     word[7:0], word[10:8]));
      return;
    end
    want = owed_replies.pop_front();
    if (word[7:0] != want.addr || word[10:8] != want.status) begin
      flag($sformatf("expected addr=%0d status=%0d, got addr=%0d status=%0d",
                     want.addr, want.status, word[7:0], word[10:8]));
    end
  endfunction

  function void report_leftover();
    while (owed_replies.size() != 0) begin
      alloc_reply_t want;
      want = owed_replies.pop_front();
      flag($sformatf("missing result addr=%0d status=%0d", want.addr, want.status));
    end
  endfunction
endclass

module first_fit_block_allocator_tb;

  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned TIMEOUT_CYCLES = 4000;
  localparam int unsigned SETTLE_CYCLES  = 2 * TB_MAX_BLOCKS + 10;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_phase     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;

  alloc_table_tracker tracker = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  first_fit_block_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Every result transfer is checked against the oldest owed reply.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // The receiver switches between stall patterns every so often.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 97 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     m_tready <= 1'b1;
      RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_tready <= (rx_phase % 5 == 0);
      default:     m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == TIMEOUT_CYCLES) begin
      $display("first_fit_block_allocator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic rest(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off new requests until every owed reply has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // Requests go out in bursts of random length; most bursts are followed by a gap.
  task automatic issue(input ffba_pkg::cmd_t cmd,
                       input logic [ffba_pkg::SIZE_W-1:0] size,
                       input logic [ffba_pkg::ADDR_W-1:0] addr,
                       input logic [ffba_pkg::OWNER_W-1:0] owner);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 16));
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, owner, addr, size};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(cmd, size, addr, owner);
  endtask

  initial begin
    int unsigned                       n;
    int unsigned                       pick;
    int unsigned                       alloc_share;
    int unsigned                       slot;
    int unsigned                       sel;
    ffba_pkg::cmd_t                    cmd;
    logic [ffba_pkg::SIZE_W-1:0]       size;
    logic [ffba_pkg::ADDR_W-1:0]       addr;
    logic [ffba_pkg::OWNER_W-1:0]      owner;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero size, then one block over all memory so nothing else fits.
    issue(ffba_pkg::CMD_ALLOC, 9'd0, 8'h00, 8'hFF);
    issue(ffba_pkg::CMD_ALLOC, 9'd256, 8'h00, 8'hA5);
    issue(ffba_pkg::CMD_ALLOC, 9'd1, 8'h00, 8'h01);
    // Wrong owner, unknown start, then a proper free.
    issue(ffba_pkg::CMD_FREE, 9'd0, 8'h00, 8'h5A);
    issue(ffba_pkg::CMD_FREE, 9'd0, 8'hFF, 8'hA5);
    issue(ffba_pkg::CMD_FREE, 9'd0, 8'h00, 8'hA5);
    // Sixteen blocks of sixteen words fill both the table and the memory.
    for (n = 0; n < TB_MAX_BLOCKS; n++) begin
      issue(ffba_pkg::CMD_ALLOC, 9'd16, 8'h00, 8'(n * 17));
    end
    issue(ffba_pkg::CMD_ALLOC, 9'd1, 8'h00, 8'h02);
    // Free a middle block, try a size one too large for the hole, then refill it.
    issue(ffba_pkg::CMD_FREE, 9'd0, 8'h80, 8'd136);
    issue(ffba_pkg::CMD_ALLOC, 9'd17, 8'h00, 8'h00);
    issue(ffba_pkg::CMD_ALLOC, 9'd16, 8'h00, 8'h3C);
    drain();

    // Mostly valid allocate and free traffic, with some noise requests mixed in.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 75) drain();
      pick        = $urandom_range(0, 99);
      alloc_share = (tracker.used >= 12) ? 35 : ((tracker.used <= 2) ? 75 : 50);
      size        = 9'($urandom_range(0, 256));
      addr        = 8'($urandom);
      owner       = 8'($urandom);
      if (pick < 8) begin
        cmd = ffba_pkg::cmd_t'($urandom_range(0, 1));
      end else if (pick < 8 + alloc_share) begin
        cmd = ffba_pkg::CMD_ALLOC;
        sel = $urandom_range(0, 19);
        if (sel < 13) size = 9'($urandom_range(1, 16));
        else if (sel < 18) size = 9'($urandom_range(17, 64));
        else size = 9'($urandom_range(65, 256));
      end else begin
        cmd = ffba_pkg::CMD_FREE;
        if (tracker.used != 0 && $urandom_range(0, 9) != 0) begin
          slot  = $urandom_range(0, tracker.used - 1);
          addr  = tracker.blocks[slot].start;
          owner = tracker.blocks[slot].owner;
          if ($urandom_range(0, 7) == 0) owner = owner ^ 8'($urandom_range(1, 255));
        end
      end
      issue(cmd, size, addr, owner);
    end

    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.report_leftover();

    $display("Covered %0d allocates and %0d frees, table fill peaked at %0d blocks.",
             tracker.n_alloc, tracker.n_free, tracker.peak_used);
    $display("Outcomes: ok %0d, zero size %0d, no block %0d, not owner %0d, no space %0d.",
             tracker.outcome_cnt[ffba_pkg::ST_OK], tracker.outcome_cnt[ffba_pkg::ST_ZERO],
             tracker.outcome_cnt[ffba_pkg::ST_NOBLOCK],
             tracker.outcome_cnt[ffba_pkg::ST_NOTOWNER],
             tracker.outcome_cnt[ffba_pkg::ST_NOSPACE]);
    if (tracker.errors == 0) begin
      $display("first_fit_block_allocator test passed");
    end else begin
      $display("first_fit_block_allocator test failed");
    end
    $finish;
  end

endmodule
